FILE: sv/rrf_pkg.sv
package rrf_pkg;

  localparam int SLOT_COUNT       = 16;
  localparam int MAX_RECORD_BYTES = 64;

  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int BOFF_W    = $clog2(MAX_RECORD_BYTES);
  localparam int LEN_W     = 7;
  localparam int CNT_W     = 5;
  localparam int MEM_DEPTH = SLOT_COUNT * MAX_RECORD_BYTES;
  localparam int ADDR_W    = SLOT_W + BOFF_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  // request codes
  localparam logic [2:0] REQ_WR_OVER = 3'd0;
  localparam logic [2:0] REQ_WR_KEEP = 3'd1;
  localparam logic [2:0] REQ_READ    = 3'd2;
  localparam logic [2:0] REQ_PEEK    = 3'd3;
  localparam logic [2:0] REQ_DROP    = 3'd4;
  localparam logic [2:0] REQ_CLEAR   = 3'd5;
  localparam logic [2:0] REQ_STATUS  = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_single;
    logic issue;
    logic load_byte;
  } rrf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic starts_stream;
    logic iss_more;
    logic out_valid;
    logic out_is_last;
  } rrf_sts_t;

endpackage

FILE: sv/record_ring_fifo_core.sv
// channel   dir  handshake              payload
// in_       in   in_valid / in_ready    req_type, data_byte, last_byte, empty_record, drop_count
// out_      out  out_valid / out_ready  status, byte, byte_valid, last_out, record_length,
//                                       stored_count, free_slots, is_full, is_empty
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a request with one result is taken whenever the controller is idle and the output
// register is free or being emptied in the same cycle
// a read or peek of a record is accepted, then read through the registered read port of the
// byte store, one byte per cycle while out_ready is high, from its single read port
// synchronous active-low reset empties the ring and restores record_size 64, 16 slots
// a stall on out_ready holds the output register and, while a record streams, the read
// port; cfg_ready is always high
module record_ring_fifo_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_req_type,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  input  logic                          in_empty_record,
  input  logic [4:0]                    in_drop_count,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_byte,
  output logic                          out_byte_valid,
  output logic                          out_last_out,
  output logic [6:0]                    out_record_length,
  output logic [4:0]                    out_stored_count,
  output logic [4:0]                    out_free_slots,
  output logic                          out_is_full,
  output logic                          out_is_empty,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrf_pkg::CFG_DAT_W-1:0] cfg_data
);

  rrf_pkg::rrf_cmd_t cmd;
  rrf_pkg::rrf_sts_t sts;

  // register writes need no wait
  assign cfg_ready = 1'b1;

  // sequencing: request accept, byte-store read issue, output loads
  rrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ring pointers, byte store, length table and output register
  rrf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .in_empty_record   (in_empty_record),
    .in_drop_count     (in_drop_count),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last_out      (out_last_out),
    .out_record_length (out_record_length),
    .out_stored_count  (out_stored_count),
    .out_free_slots    (out_free_slots),
    .out_is_full       (out_is_full),
    .out_is_empty      (out_is_empty)
  );

  // no new request while a record is still streaming out
  a_no_accept_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_ready)
    else $error("request accepted during record stream");

  // a request is only taken when the output register can hold its result
  a_accept_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("request accepted with output register occupied");

  // a result without record data is always the final one and carries no byte or length
  a_nobyte_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |->
      (out_last_out && out_byte == 8'd0 && out_record_length == 7'd0))
    else $error("non-data result malformed");

  // occupancy fields agree with each other
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_stored_count == 5'd0)) &&
                  (out_is_full == (out_free_slots == 5'd0)))
    else $error("occupancy flags inconsistent");

endmodule

FILE: sv/rrf_ctrl.sv
module rrf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  input  rrf_pkg::rrf_sts_t sts,
  output rrf_pkg::rrf_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic   out_free;

  assign out_free = !sts.out_valid || out_ready;

  always_comb begin
    state_nxt       = state_r;
    pend_nxt        = pend_r;
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.load_single = 1'b0;
    cmd.issue       = 1'b0;
    cmd.load_byte   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = out_free;
        cmd.accept = in_valid && out_free;
        if (cmd.accept) begin
          if (sts.starts_stream) begin
            state_nxt = S_STREAM;
            pend_nxt  = 1'b0;
          end else begin
            cmd.load_single = 1'b1;
          end
        end
      end
      S_STREAM: begin
        // one memory read in flight at most, refilled as the byte moves out
        cmd.load_byte = pend_r && out_free;
        cmd.issue     = sts.iss_more && (!pend_r || cmd.load_byte);
        pend_nxt      = cmd.issue || (pend_r && !cmd.load_byte);
        if (cmd.load_byte && sts.out_is_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

FILE: sv/rrf_datapath.sv
module rrf_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rrf_pkg::rrf_cmd_t              cmd,
  output rrf_pkg::rrf_sts_t              sts,
  input  logic [2:0]                     in_req_type,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  input  logic                           in_empty_record,
  input  logic [4:0]                     in_drop_count,
  input  logic                           cfg_we,
  input  logic [rrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrf_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [7:0]                     out_byte,
  output logic                           out_byte_valid,
  output logic                           out_last_out,
  output logic [6:0]                     out_record_length,
  output logic [4:0]                     out_stored_count,
  output logic [4:0]                     out_free_slots,
  output logic                           out_is_full,
  output logic                           out_is_empty
);

  localparam int SW = rrf_pkg::SLOT_W;
  localparam int LW = rrf_pkg::LEN_W;
  localparam int CW = rrf_pkg::CNT_W;
  localparam int BW = rrf_pkg::BOFF_W;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s,
                                              input logic [CW-1:0] n);
    logic [CW-1:0] inc;
    inc = CW'(s) + CW'(1);
    return (inc >= n) ? '0 : inc[SW-1:0];
  endfunction

  // ring state
  logic [LW-1:0] rec_size_r, rec_size_nxt;
  logic [CW-1:0] slots_r, slots_nxt;
  logic [SW-1:0] wr_slot_r, wr_slot_nxt;
  logic [SW-1:0] rd_slot_r, rd_slot_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [LW-1:0] open_len_r, open_len_nxt;
  logic          open_ref_r, open_ref_nxt;
  logic [LW-1:0] len_store_r [rrf_pkg::SLOT_COUNT];
  logic [7:0]    byte_mem [rrf_pkg::MEM_DEPTH];

  // read stream
  logic [SW-1:0] str_slot_r;
  logic [LW-1:0] str_len_r;
  logic [LW-1:0] iss_idx_r;
  logic [LW-1:0] out_idx_r;
  logic [7:0]    rd_byte_r;

  // output register
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_byte_r;
  logic          out_bv_r;
  logic          out_last_r;
  logic [LW-1:0] out_len_r;
  logic [CW-1:0] out_cnt_r;
  logic [CW-1:0] out_free_r;
  logic          out_full_r;
  logic          out_empty_r;

  logic               full, empty, opening, ends;
  logic [1:0]         st;
  logic               mem_we, len_we, starts;
  logic [LW-1:0]      len_wdata, w_len, rd_len, cur_len;
  logic [CW:0]        drop_sum;
  logic [CW-1:0]      free_nxt, free_cur;
  logic [CW-1:0]      cfg_slots;
  logic [LW-1:0]      cfg_size;

  assign full    = held_r >= slots_r;
  assign empty   = held_r == '0;
  assign opening = (open_len_r == '0) && !open_ref_r;
  assign ends    = in_last_byte || in_empty_record;
  assign cur_len = len_store_r[rd_slot_r];
  assign rd_len  = (cur_len > rec_size_r) ? rec_size_r : cur_len;
  assign drop_sum = (CW+1)'(rd_slot_r) + (CW+1)'(in_drop_count);

  // read or peek of a held record with bytes goes out as a stream
  assign starts = (in_req_type inside {rrf_pkg::REQ_READ, rrf_pkg::REQ_PEEK}) &&
                  !empty && (rd_len != '0);

  // clamp configuration values into range
  always_comb begin
    cfg_size = cfg_data;
    if (cfg_size == '0) cfg_size = LW'(1);
    if (cfg_size > LW'(rrf_pkg::MAX_RECORD_BYTES)) cfg_size = LW'(rrf_pkg::MAX_RECORD_BYTES);
    cfg_slots = cfg_data[CW-1:0];
    if (cfg_slots == '0) cfg_slots = CW'(1);
    if (cfg_slots > CW'(rrf_pkg::SLOT_COUNT)) cfg_slots = CW'(rrf_pkg::SLOT_COUNT);
  end

  always_comb begin
    rec_size_nxt = rec_size_r;
    slots_nxt    = slots_r;
    wr_slot_nxt  = wr_slot_r;
    rd_slot_nxt  = rd_slot_r;
    held_nxt     = held_r;
    open_len_nxt = open_len_r;
    open_ref_nxt = open_ref_r;
    st           = rrf_pkg::ST_OK;
    mem_we       = 1'b0;
    len_we       = 1'b0;
    len_wdata    = open_len_r;
    w_len        = open_len_r;
    if (cfg_we) begin
      if (cfg_index == rrf_pkg::CFG_RECORD_SIZE) begin
        rec_size_nxt = cfg_size;
      end
      if (cfg_index == rrf_pkg::CFG_SLOTS_IN_USE) begin
        slots_nxt = cfg_slots;
      end
      if (cfg_index == rrf_pkg::CFG_RECORD_SIZE || cfg_index == rrf_pkg::CFG_SLOTS_IN_USE) begin
        wr_slot_nxt  = '0;
        rd_slot_nxt  = '0;
        held_nxt     = '0;
        open_len_nxt = '0;
        open_ref_nxt = 1'b0;
      end
    end else if (cmd.accept) begin
      case (in_req_type)
        rrf_pkg::REQ_WR_OVER, rrf_pkg::REQ_WR_KEEP: begin
          if (opening && full) begin
            st = rrf_pkg::ST_FULL;
            if (in_req_type == rrf_pkg::REQ_WR_KEEP) begin
              open_ref_nxt = 1'b1;
            end else begin
              rd_slot_nxt = next_slot(rd_slot_r, slots_r);
              held_nxt    = held_r - CW'(1);
            end
          end
          if (open_ref_nxt) begin
            st = rrf_pkg::ST_FULL;
            if (ends) open_ref_nxt = 1'b0;
          end else begin
            if (!in_empty_record && open_len_r < rec_size_r) begin
              mem_we = 1'b1;
              w_len  = open_len_r + LW'(1);
            end
            open_len_nxt = w_len;
            if (ends) begin
              len_we       = 1'b1;
              len_wdata    = w_len;
              wr_slot_nxt  = next_slot(wr_slot_r, slots_r);
              held_nxt     = held_nxt + CW'(1);
              open_len_nxt = '0;
            end
          end
        end
        rrf_pkg::REQ_READ, rrf_pkg::REQ_PEEK: begin
          if (empty) begin
            st = rrf_pkg::ST_ERR;
          end else begin
            if (in_req_type == rrf_pkg::REQ_READ) begin
              rd_slot_nxt = next_slot(rd_slot_r, slots_r);
              held_nxt    = held_r - CW'(1);
            end
          end
        end
        rrf_pkg::REQ_DROP: begin
          if (empty || in_drop_count > held_r) begin
            st = rrf_pkg::ST_ERR;
          end else begin
            rd_slot_nxt = (drop_sum >= (CW+1)'(slots_r)) ?
                          SW'(drop_sum - (CW+1)'(slots_r)) : SW'(drop_sum);
            held_nxt    = held_r - in_drop_count;
          end
        end
        rrf_pkg::REQ_CLEAR: begin
          wr_slot_nxt  = '0;
          rd_slot_nxt  = '0;
          held_nxt     = '0;
          open_len_nxt = '0;
          open_ref_nxt = 1'b0;
        end
        rrf_pkg::REQ_STATUS: begin
          st = rrf_pkg::ST_OK;
        end
        default: begin
          st = rrf_pkg::ST_ERR;
        end
      endcase
    end
  end

  assign free_nxt = (slots_r > held_nxt) ? slots_r - held_nxt : '0;
  assign free_cur = (slots_r > held_r) ? slots_r - held_r : '0;

  assign sts.starts_stream = starts;
  assign sts.iss_more      = iss_idx_r < str_len_r;
  assign sts.out_valid     = out_valid_r;
  assign sts.out_is_last   = (out_idx_r + LW'(1)) == str_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_size_r  <= LW'(rrf_pkg::MAX_RECORD_BYTES);
      slots_r     <= CW'(rrf_pkg::SLOT_COUNT);
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      held_r      <= '0;
      open_len_r  <= '0;
      open_ref_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rec_size_r  <= rec_size_nxt;
      slots_r     <= slots_nxt;
      wr_slot_r   <= wr_slot_nxt;
      rd_slot_r   <= rd_slot_nxt;
      held_r      <= held_nxt;
      open_len_r  <= open_len_nxt;
      open_ref_r  <= open_ref_nxt;
      if (cmd.load_single || cmd.load_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[{wr_slot_r, open_len_r[BW-1:0]}] <= in_data_byte;
    end
    if (cmd.issue) begin
      rd_byte_r <= byte_mem[{str_slot_r, iss_idx_r[BW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_store_r[wr_slot_r] <= len_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && starts) begin
      str_slot_r <= rd_slot_r;
      str_len_r  <= rd_len;
      iss_idx_r  <= '0;
      out_idx_r  <= '0;
    end else begin
      if (cmd.issue)     iss_idx_r <= iss_idx_r + LW'(1);
      if (cmd.load_byte) out_idx_r <= out_idx_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_status_r <= st;
      out_byte_r   <= '0;
      out_bv_r     <= 1'b0;
      out_last_r   <= 1'b1;
      out_len_r    <= '0;
      out_cnt_r    <= held_nxt;
      out_free_r   <= free_nxt;
      out_full_r   <= held_nxt >= slots_r;
      out_empty_r  <= held_nxt == '0;
    end else if (cmd.load_byte) begin
      out_status_r <= rrf_pkg::ST_OK;
      out_byte_r   <= rd_byte_r;
      out_bv_r     <= 1'b1;
      out_last_r   <= sts.out_is_last;
      out_len_r    <= str_len_r;
      out_cnt_r    <= held_r;
      out_free_r   <= free_cur;
      out_full_r   <= full;
      out_empty_r  <= empty;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_byte          = out_byte_r;
  assign out_byte_valid    = out_bv_r;
  assign out_last_out      = out_last_r;
  assign out_record_length = out_len_r;
  assign out_stored_count  = out_cnt_r;
  assign out_free_slots    = out_free_r;
  assign out_is_full       = out_full_r;
  assign out_is_empty      = out_empty_r;

endmodule
